/* src/srs_pkg.sv */
// ---------------------------------------------------------------------------
// srs_pkg: shared types and constants for the reaction step engine
// Request codes, status codes, sequencer states and fixed constants.
// ---------------------------------------------------------------------------
package srs_pkg;

    localparam int MAX_SPECIES_D   = 16;
    localparam int MAX_REACTIONS_D = 32;
    localparam int MAX_PRODUCTS_D  = 4;
    localparam int COUNT_BITS_D    = 32;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [47:0] TSTEP_MAX = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        REQ_HEAD  = 3'd0,
        REQ_PROD  = 3'd1,
        REQ_WRITE = 3'd2,
        REQ_READ  = 3'd3,
        REQ_STEP  = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE, S_P_RD, S_P_MUL1, S_P_MUL2, S_P_ACC, S_TOT,
        S_LN_MUL, S_LN_SQ, S_LN_FIN1, S_LN_FIN2,
        S_TGT1, S_TGT2, S_SEL_RD, S_SEL_CMP,
        S_DIV, S_DIV_FIN,
        S_RC_RD, S_RC_WR, S_PR_RD, S_PR_RDC, S_PR_WR,
        S_OUT
    } state_t;

endpackage

/* src/srs_divider.sv */
// ---------------------------------------------------------------------------
// srs_divider: restoring divider, one quotient bit per cycle
// Divides a 64-bit dividend by a 64-bit divisor.
// ---------------------------------------------------------------------------
module srs_divider
    import srs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        busy,
    output logic [63:0] quotient
);

    logic [6:0]  cnt_reg, cnt_next;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] dsr_reg, dsr_next;
    logic [64:0] trial;

    // one shift-subtract step
    always_comb begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dsr_next = dsr_reg;
        trial    = {rem_reg[63:0], quo_reg[63]};
        if (start) begin
            cnt_next = 7'd64;
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
        end else if (cnt_reg != 7'd0) begin
            cnt_next = cnt_reg - 7'd1;
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = (cnt_reg != 7'd0);
    assign quotient = quo_reg;

endmodule

/* src/stochastic_reaction_step.sv */
// ---------------------------------------------------------------------------
// stochastic_reaction_step: Gillespie direct-method step engine
// Table loads, count access and one stochastic step per request word.
// ---------------------------------------------------------------------------
// Each request word gives one result word. A load or read is accepted in
// the idle state and its result is presented in the output state. A step
// runs one shared 32x32 multiplier under a sequencer: the propensities of
// the R reactions in use, 32 squaring rounds for the logarithm, the
// selection, the bit-serial divider, and an update per changed count. The
// block takes no new word until the result is taken. Table storage is
// undefined until written; counts reset to zero.
module stochastic_reaction_step
    import srs_pkg::*;
#(
    parameter int MAX_SPECIES   = MAX_SPECIES_D,
    parameter int MAX_REACTIONS = MAX_REACTIONS_D,
    parameter int MAX_PRODUCTS  = MAX_PRODUCTS_D,
    parameter int COUNT_BITS    = COUNT_BITS_D
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // req_type[2:0], item_index[7:3], value[39:8], reactant_count[41:40],
    // reactant_a[45:42], reactant_b[49:46], product_count[52:50],
    // product_slot[54:53], product_species[58:55], product_change[62:59],
    // random_select[94:63], random_time[126:95], zero fill [127]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], reaction_index[6:2], time_step[54:7],
    // elapsed_time[118:55], read_count[150:119], zero fill [151]
    output logic [151:0] m_tdata,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [5:0]   cfg_data
);

    localparam int RW = (MAX_REACTIONS > 1) ? $clog2(MAX_REACTIONS) : 1;
    localparam int SW = $clog2(MAX_SPECIES);
    localparam int PD = MAX_REACTIONS * MAX_PRODUCTS;
    localparam int PAW = $clog2(PD) > 0 ? $clog2(PD) : 1;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF >> (32 - COUNT_BITS);

    // unpack the request word
    logic [2:0]  in_type;
    logic [4:0]  in_idx;
    logic [31:0] in_value, in_rsel, in_rtime;
    logic [1:0]  in_rc, in_slot;
    logic [3:0]  in_ra, in_rb, in_ps, in_pch;
    logic [2:0]  in_pc;
    assign in_type  = s_tdata[2:0];
    assign in_idx   = s_tdata[7:3];
    assign in_value = s_tdata[39:8];
    assign in_rc    = s_tdata[41:40];
    assign in_ra    = s_tdata[45:42];
    assign in_rb    = s_tdata[49:46];
    assign in_pc    = s_tdata[52:50];
    assign in_slot  = s_tdata[54:53];
    assign in_ps    = s_tdata[58:55];
    assign in_pch   = s_tdata[62:59];
    assign in_rsel  = s_tdata[94:63];
    assign in_rtime = s_tdata[126:95];

    // configuration
    logic [4:0] nsp_reg;
    logic [5:0] nrx_reg;
    logic [8:0]  eff_sp;
    logic [10:0] eff_rx;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nsp_reg <= 5'd16;
            nrx_reg <= 6'd1;
        end else if (cfg_we) begin
            if (cfg_index == 1'b0) nsp_reg <= cfg_data[4:0];
            else                   nrx_reg <= cfg_data;
        end
    end
    assign eff_sp = ({4'd0, nsp_reg} < 9'(MAX_SPECIES)) ? {4'd0, nsp_reg}
                                                          : 9'(MAX_SPECIES);
    assign eff_rx = ({5'd0, nrx_reg} < 11'(MAX_REACTIONS)) ? {5'd0, nrx_reg}
                                                             : 11'(MAX_REACTIONS);

    // storage
    logic [31:0] counts_reg [MAX_SPECIES];
    logic [31:0] rate_mem   [MAX_REACTIONS];
    logic [9:0]  react_mem  [MAX_REACTIONS];
    logic [2:0]  pcnt_mem   [MAX_REACTIONS];
    logic [7:0]  prod_mem   [PD];
    logic [63:0] prop_mem   [MAX_REACTIONS];

    // request latch
    logic [31:0] rsel_reg, rtime_reg;

    state_t      state_reg, state_next;
    logic [RW:0] r_reg, r_next;
    logic [5:0]  k_reg, k_next;
    logic [63:0] tot_reg, tot_next, acc_reg, acc_next, tmp_reg, tmp_next;
    logic [63:0] time_reg, time_next, tgt_reg, tgt_next;
    logic [63:0] m_reg, m_next;
    logic [31:0] f_reg, f_next;
    logic [5:0]  e_reg, e_next;
    logic [1:0]  status_reg, status_next;
    logic [RW-1:0] sel_reg, sel_next;
    logic [47:0] ts_reg, ts_next;
    logic [31:0] rdc_reg, rdc_next;
    logic [31:0] xb_reg, xb_next;
    logic [9:0]  rx_rd_reg;
    logic [31:0] rate_rd_reg;
    logic [2:0]  pc_rd_reg;
    logic [7:0]  pe_rd_reg;
    logic [63:0] prop_rd_reg;
    logic        div_start;
    logic        div_busy;
    logic [63:0] div_q;
    logic [3:0]  tgt_sp_reg, tgt_sp_next;
    logic [32:0] cval_reg, cval_next;

    // shared multiplier, operands chosen by the sequencer
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    srs_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (tot_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [31:0] cnt_of(input logic [3:0] s, input logic [31:0] c,
                                           input logic [8:0] n);
        return ({5'd0, s} < n) ? c : 32'd0;
    endfunction

    logic [3:0] ra_cur, rb_cur;
    logic [1:0] nreact;
    assign ra_cur = rx_rd_reg[7:4];
    assign rb_cur = rx_rd_reg[3:0];
    assign nreact = (rx_rd_reg[9:8] == 2'd3) ? 2'd2 : rx_rd_reg[9:8];

    logic [RW-1:0] r_idx;
    logic [PAW-1:0] p_addr;
    logic           prop_phase;
    assign r_idx  = r_reg[RW-1:0];
    assign p_addr = PAW'(sel_reg) * PAW'(MAX_PRODUCTS) + PAW'(k_reg);
    // hold the reaction head of the current reaction through its propensity
    assign prop_phase = (state_reg == S_P_RD) || (state_reg == S_P_MUL1)
                        || (state_reg == S_P_MUL2);

    // registered table reads
    always_ff @(posedge aclk) begin
        rx_rd_reg   <= react_mem[prop_phase ? r_idx : sel_reg];
        rate_rd_reg <= rate_mem[r_idx];
        pc_rd_reg   <= pcnt_mem[sel_reg];
        pe_rd_reg   <= prod_mem[p_addr];
        prop_rd_reg <= prop_mem[r_idx];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (in_type != REQ_STEP) state_next = S_OUT;
                    else if (eff_rx == 11'd0) state_next = S_TOT;
                    else state_next = S_P_RD;
                end
            end
            S_P_RD: state_next = S_P_MUL1;
            S_P_MUL1: state_next = S_P_MUL2;
            S_P_MUL2: state_next = S_P_ACC;
            S_P_ACC: state_next = ((r_reg + 1'b1) >= eff_rx[RW:0]) ? S_TOT : S_P_RD;
            S_TOT: state_next = (tot_reg == 64'd0) ? S_OUT : S_LN_MUL;
            S_LN_MUL: state_next = S_LN_SQ;
            S_LN_SQ: state_next = (k_reg == 6'd31) ? S_LN_FIN1 : S_LN_MUL;
            S_LN_FIN1: state_next = S_LN_FIN2;
            S_LN_FIN2: state_next = S_TGT1;
            S_TGT1: state_next = S_TGT2;
            S_TGT2: state_next = S_SEL_RD;
            S_SEL_RD: state_next = S_SEL_CMP;
            S_SEL_CMP: begin
                if (sat_add(tmp_reg, prop_rd_reg) >= tgt_reg
                    || (r_reg + 1'b1) >= eff_rx[RW:0])
                    state_next = S_DIV;
                else
                    state_next = S_SEL_RD;
            end
            S_DIV: state_next = S_DIV_FIN;
            S_DIV_FIN: if (!div_busy) state_next = S_RC_RD;
            S_RC_RD: state_next = (k_reg[1:0] >= nreact) ? S_PR_RD : S_RC_WR;
            S_RC_WR: state_next = S_RC_RD;
            S_PR_RD: state_next = S_PR_RDC;
            S_PR_RDC: begin
                if ({3'd0, k_reg} >= ((pc_rd_reg > 3'(MAX_PRODUCTS)) ?
                        9'(MAX_PRODUCTS) : {6'd0, pc_rd_reg}))
                    state_next = S_OUT;
                else
                    state_next = S_PR_WR;
            end
            S_PR_WR: state_next = S_PR_RD;
            S_OUT: if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath control
    logic [3:0]  cs;
    logic [31:0] cc;
    logic [63:0] msq;
    logic [31:0] xa_cnt;
    logic [31:0] xb_same;
    logic [63:0] n_val;
    logic [34:0] cv_add;
    always_comb begin
        r_next = r_reg; k_next = k_reg; tot_next = tot_reg; acc_next = acc_reg;
        tmp_next = tmp_reg; time_next = time_reg; tgt_next = tgt_reg;
        m_next = m_reg; f_next = f_reg; e_next = e_reg;
        status_next = status_reg; sel_next = sel_reg; ts_next = ts_reg;
        rdc_next = rdc_reg; xb_next = xb_reg;
        tgt_sp_next = tgt_sp_reg; cval_next = cval_reg;
        div_start = 1'b0;
        mul_a = '0; mul_b = '0;
        cs = '0; cc = '0; msq = '0; xa_cnt = '0; xb_same = '0; n_val = '0; cv_add = '0;
        unique case (state_reg)
            S_IDLE: begin
                r_next = '0; tot_next = '0; status_next = ST_OK;
                ts_next = '0; rdc_next = '0; sel_next = '0;
                // range-check a load or read as the word is taken
                if (s_tvalid) begin
                    unique case (in_type)
                        REQ_HEAD, REQ_PROD:
                            if ({6'd0, in_idx} >= eff_rx ||
                                (in_type == REQ_PROD && 9'(in_slot) >= 9'(MAX_PRODUCTS)))
                                status_next = ST_RANGE;
                        REQ_WRITE, REQ_READ: begin
                            if ({4'd0, in_idx} >= eff_sp) status_next = ST_RANGE;
                            else if (in_type == REQ_READ)
                                rdc_next = counts_reg[in_idx[SW-1:0]];
                        end
                        REQ_STEP: ;
                        default: status_next = ST_RANGE;
                    endcase
                end
            end
            S_P_RD: ;
            S_P_MUL1: begin
                xa_cnt = cnt_of(ra_cur, counts_reg[ra_cur], eff_sp);
                xb_same = (xa_cnt != 32'd0) ? xa_cnt - 32'd1 : 32'd0;
                xb_next = (ra_cur == rb_cur) ? xb_same
                        : cnt_of(rb_cur, counts_reg[rb_cur], eff_sp);
                mul_a = rate_rd_reg; mul_b = xa_cnt;
                tmp_next = (nreact == 2'd0) ? {32'd0, rate_rd_reg} : mul_p;
            end
            S_P_MUL2: begin
                // high partial product of k*xa*xb
                mul_a = tmp_reg[63:32]; mul_b = xb_reg;
                m_next = (nreact == 2'd2) ? mul_p : 64'd0;
            end
            S_P_ACC: begin
                if (nreact == 2'd2) begin
                    // low partial product, then combine with saturation
                    mul_a = tmp_reg[31:0]; mul_b = xb_reg;
                    n_val = mul_p;
                    if (m_reg[63:32] != 32'd0) tmp_next = '1;
                    else begin
                        cv_add = 35'(m_reg[31:0]) + 35'(n_val[63:32]);
                        tmp_next = (cv_add[34:32] != 3'd0) ? '1
                                 : {cv_add[31:0], n_val[31:0]};
                    end
                end
                tot_next = sat_add(tot_reg, tmp_next);
                r_next = r_reg + 1'b1;
                // prepare log: normalize
                k_next = '0; f_next = '0;
                e_next = 6'd31;
                for (int i = 0; i < 32; i++)
                    if (rtime_reg[i] || (rtime_reg == 32'd0 && i == 0)) e_next = 6'(i);
                m_next = {32'd0, (rtime_reg == 32'd0) ? 32'd1 : rtime_reg}
                         << (6'd31 - e_next);
            end
            S_TOT: begin
                if (tot_reg == 64'd0) status_next = ST_NONE;
            end
            S_LN_MUL: begin
                mul_a = m_reg[31:0]; mul_b = m_reg[31:0];
                m_next = mul_p;
            end
            S_LN_SQ: begin
                msq = m_reg >> 31;
                if (msq >= 64'h1_0000_0000) begin
                    m_next = msq >> 1; f_next = {f_reg[30:0], 1'b1};
                end else begin
                    m_next = msq; f_next = {f_reg[30:0], 1'b0};
                end
                k_next = k_reg + 6'd1;
            end
            S_LN_FIN1: begin
                n_val = {26'd0, 6'd32 - e_reg, 32'd0} - {32'd0, f_reg};
                mul_a = n_val[31:0]; mul_b = LN2_Q32;
                tmp_next = mul_p >> 16;
                m_next = {32'd0, n_val[63:32]};
            end
            S_LN_FIN2: begin
                mul_a = m_reg[31:0]; mul_b = LN2_Q32;
                acc_next = (mul_p << 16) + tmp_reg;
            end
            S_TGT1: begin
                mul_a = (rsel_reg == 32'd0) ? 32'd1 : rsel_reg;
                mul_b = tot_reg[31:0];
                tmp_next = mul_p;
            end
            S_TGT2: begin
                mul_a = (rsel_reg == 32'd0) ? 32'd1 : rsel_reg;
                mul_b = tot_reg[63:32];
                tgt_next = mul_p + {32'd0, tmp_reg[63:32]}
                         + {63'd0, tmp_reg[31:0] != 32'd0};
                tmp_next = '0; r_next = '0;
            end
            S_SEL_RD: ;
            S_SEL_CMP: begin
                tmp_next = sat_add(tmp_reg, prop_rd_reg);
                sel_next = r_idx;
                r_next = r_reg + 1'b1;
            end
            S_DIV: begin
                div_start = 1'b1; k_next = '0;
            end
            S_DIV_FIN: begin
                ts_next = (div_q[63:48] != 16'd0) ? TSTEP_MAX : div_q[47:0];
                if (!div_busy)
                    time_next = sat_add(time_reg, {16'd0, ts_next});
            end
            S_RC_RD: begin
                cs = (k_reg == 6'd0) ? ra_cur : rb_cur;
                tgt_sp_next = cs;
                cc = cnt_of(cs, counts_reg[cs], eff_sp);
                cval_next = (cc != 32'd0) ? {1'b0, cc - 32'd1} : 33'd0;
                if (k_reg[1:0] >= nreact) k_next = '0;
            end
            S_RC_WR: k_next = k_reg + 6'd1;
            S_PR_RD: ;
            S_PR_RDC: begin
                cs = pe_rd_reg[7:4];
                tgt_sp_next = cs;
                cc = cnt_of(cs, counts_reg[cs], eff_sp);
                cv_add = {3'd0, cc} + {{31{pe_rd_reg[3]}}, pe_rd_reg[3:0]};
                cval_next = cv_add[34] ? 33'd0 : cv_add[32:0];
            end
            S_PR_WR: k_next = k_reg + 6'd1;
            S_OUT: ;
            default: ;
        endcase
    end

    // store propensities and table loads
    always_ff @(posedge aclk) begin
        if (state_reg == S_P_ACC) prop_mem[r_idx] <= tmp_next;
        if (state_reg == S_IDLE && s_tvalid && in_type == REQ_HEAD
            && {6'd0, in_idx} < eff_rx) begin
            rate_mem[in_idx[RW-1:0]]  <= in_value;
            react_mem[in_idx[RW-1:0]] <= {in_rc, in_ra, in_rb};
            pcnt_mem[in_idx[RW-1:0]]  <= in_pc;
        end
        if (state_reg == S_IDLE && s_tvalid && in_type == REQ_PROD
            && {6'd0, in_idx} < eff_rx && 9'(in_slot) < 9'(MAX_PRODUCTS))
            prod_mem[PAW'(in_idx) * PAW'(MAX_PRODUCTS) + PAW'(in_slot)]
                <= {in_ps, in_pch};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_SPECIES; i++) counts_reg[i] <= '0;
        end else if (state_reg == S_IDLE && s_tvalid && in_type == REQ_WRITE
                     && {4'd0, in_idx} < eff_sp) begin
            counts_reg[in_idx[SW-1:0]] <= (in_value > COUNT_MAX) ? COUNT_MAX : in_value;
        end else if ((state_reg == S_RC_WR || state_reg == S_PR_WR)
                     && {5'd0, tgt_sp_reg} < eff_sp) begin
            counts_reg[tgt_sp_reg] <= (cval_reg > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                                    : cval_reg[31:0];
        end
    end

    // control and working registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            time_reg  <= '0;
        end else begin
            state_reg <= state_next;
            time_reg  <= time_next;
        end
        if (state_reg == S_IDLE && s_tvalid) begin
            rsel_reg <= in_rsel; rtime_reg <= in_rtime;
        end
        r_reg <= r_next; k_reg <= k_next; tot_reg <= tot_next; acc_reg <= acc_next;
        tmp_reg <= tmp_next; tgt_reg <= tgt_next; m_reg <= m_next; f_reg <= f_next;
        e_reg <= e_next; status_reg <= status_next; sel_reg <= sel_next;
        ts_reg <= ts_next; rdc_reg <= rdc_next; xb_reg <= xb_next;
        tgt_sp_reg <= tgt_sp_next; cval_reg <= cval_next;
    end

    // outputs
    always_comb begin
        s_tready = (state_reg == S_IDLE);
        m_tvalid = (state_reg == S_OUT);
        m_tdata  = {1'b0, rdc_reg, time_reg, ts_reg, 5'(sel_reg), status_reg};
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_time_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> time_reg >= $past(time_reg)) else $error("time fell");
`endif

endmodule
